>>> hdl/cal_pkg.sv
`timescale 1ns / 1ps

package cal_pkg;

	// Field widths
	localparam int unsigned SPT_W   = 6;
	localparam int unsigned HEADS_W = 8;
	localparam int unsigned CYL_W   = 10;
	localparam int unsigned PCYL_W  = SPT_W + HEADS_W;
	localparam int unsigned CHS_W   = 24;
	localparam int unsigned LBA_W   = 32;
	localparam int unsigned LBAO_W  = 24;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 8;

	// Geometry after reset
	localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd63;
	localparam logic [HEADS_W-1:0] HEADS_RESET = 8'd255;

	// Cylinder that marks an unused entry, and the clamp value on output
	localparam logic [CYL_W-1:0] CYL_SENTINEL = 10'd1023;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADS = 8'd1;

	// Command codes
	localparam logic CMD_CHS_TO_LBA = 1'b0;
	localparam logic CMD_LBA_TO_CHS = 1'b1;

	// Current disc geometry, shared with all stages
	typedef struct packed {
		logic [SPT_W-1:0]   spt;
		logic [HEADS_W-1:0] heads;
		logic [PCYL_W-1:0]  per_cyl;
		logic               zero;
	} cal_geom_t;

	// Payload that travels through the divider stages
	typedef struct packed {
		logic              cmd;
		logic              zero;
		logic              clamp;
		logic [LBAO_W-1:0] lba_res;
		logic [LBAO_W-1:0] rem;
		logic [CYL_W-1:0]  cyl;
		logic [7:0]        head;
	} cal_div_t;

endpackage

>>> hdl/cal_front.sv
`timescale 1ns / 1ps

module cal_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cal_pkg::cal_geom_t      geom,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_cmd,
	input  logic [cal_pkg::CHS_W-1:0] in_chs,
	input  logic [cal_pkg::LBA_W-1:0] in_lba,
	output logic                    out_valid,
	input  logic                    out_ready,
	output cal_pkg::cal_div_t       out_data
);

	typedef struct packed {
		logic                       cmd;
		logic                       zero;
		logic                       clamp;
		logic                       blank;
		logic [cal_pkg::LBAO_W-1:0] lba;
		logic [7:0]                 head;
		logic [cal_pkg::SPT_W-1:0]  sec;
		logic [17:0]                m1;
	} cal_f1_t;

	typedef struct packed {
		logic                       cmd;
		logic                       zero;
		logic                       clamp;
		logic                       blank;
		logic [cal_pkg::LBAO_W-1:0] lba;
		logic [cal_pkg::SPT_W-1:0]  sec;
		logic [23:0]                m2;
	} cal_f2_t;

	cal_f1_t           data_s1;
	cal_f2_t           data_s2;
	cal_pkg::cal_div_t data_s3;
	logic              valid_s1, valid_s2, valid_s3;
	logic              en1, en2, en3;

	logic [cal_pkg::CYL_W-1:0] cyl_in;
	logic [17:0]               v_sum;
	logic [24:0]               lba_sum;

	// Each stage loads when empty or when the next one moves
	assign en3      = !valid_s3 || out_ready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	assign cyl_in  = {in_chs[15:14], in_chs[23:16]};
	assign v_sum   = {10'd0, data_s1.head} + data_s1.m1;
	assign lba_sum = {1'b0, data_s2.m2} + {19'd0, data_s2.sec} - 25'd1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: unpack, heads * cylinder, cylinder range check, blank entry check
	always_ff @(posedge clk) begin
		if (en1) begin
			data_s1.cmd   <= in_cmd;
			data_s1.zero  <= geom.zero;
			data_s1.clamp <= (in_lba[cal_pkg::LBA_W-1:cal_pkg::CYL_W]
				>= {8'd0, geom.per_cyl});
			data_s1.blank <= (cyl_in == cal_pkg::CYL_SENTINEL) || (in_chs[13:8] == 6'd0);
			data_s1.lba   <= in_lba[cal_pkg::LBAO_W-1:0];
			data_s1.head  <= in_chs[7:0];
			data_s1.sec   <= in_chs[13:8];
			data_s1.m1    <= {10'd0, geom.heads} * {8'd0, cyl_in};
		end
	end

	// Stage 2: spt * (head + heads * cyl)
	always_ff @(posedge clk) begin
		if (en2) begin
			data_s2.cmd   <= data_s1.cmd;
			data_s2.zero  <= data_s1.zero;
			data_s2.clamp <= data_s1.clamp;
			data_s2.blank <= data_s1.blank;
			data_s2.lba   <= data_s1.lba;
			data_s2.sec   <= data_s1.sec;
			data_s2.m2    <= {18'd0, geom.spt} * {6'd0, v_sum};
		end
	end

	// Stage 3: add sector, drop one, seed the divider
	always_ff @(posedge clk) begin
		if (en3) begin
			data_s3.cmd     <= data_s2.cmd;
			data_s3.zero    <= data_s2.zero;
			data_s3.clamp   <= data_s2.clamp;
			data_s3.lba_res <= data_s2.blank ? '0 : lba_sum[cal_pkg::LBAO_W-1:0];
			data_s3.rem     <= data_s2.lba;
			data_s3.cyl     <= '0;
			data_s3.head    <= '0;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

>>> hdl/cal_div_step.sv
`timescale 1ns / 1ps

module cal_div_step #(
	parameter int unsigned SHIFT      = 0,
	parameter bit          HEAD_PHASE = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cal_pkg::cal_geom_t geom,
	input  logic               in_valid,
	output logic               in_ready,
	input  cal_pkg::cal_div_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output cal_pkg::cal_div_t  out_data
);

	cal_pkg::cal_div_t          data_s1;
	logic                       valid_s1;
	logic                       en;
	logic [cal_pkg::LBAO_W-1:0] dvs;
	logic                       take;
	cal_pkg::cal_div_t          nxt;

	assign en       = !valid_s1 || out_ready;
	assign in_ready = en;

	// Shifted divisor: cylinder size first, then track size
	generate
		if (HEAD_PHASE) begin : g_head
			assign dvs = {18'd0, geom.spt} << SHIFT;
		end else begin : g_cyl
			assign dvs = {10'd0, geom.per_cyl} << SHIFT;
		end
	endgenerate

	assign take = in_data.rem >= dvs;

	// One restoring step: subtract and set the quotient bit
	generate
		if (HEAD_PHASE) begin : g_qh
			always_comb begin
				nxt = in_data;
				if (take) begin
					nxt.rem        = in_data.rem - dvs;
					nxt.head[SHIFT] = 1'b1;
				end
			end
		end else begin : g_qc
			always_comb begin
				nxt = in_data;
				if (take) begin
					nxt.rem       = in_data.rem - dvs;
					nxt.cyl[SHIFT] = 1'b1;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

>>> hdl/cal_back.sv
`timescale 1ns / 1ps

module cal_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cal_pkg::cal_geom_t geom,
	input  logic               in_valid,
	output logic               in_ready,
	input  cal_pkg::cal_div_t  in_data,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata
);

	logic                       valid_q;
	logic [47:0]                tdata_q;
	logic                       en;
	logic [cal_pkg::CYL_W-1:0]  cyl;
	logic [7:0]                 head;
	logic [cal_pkg::SPT_W-1:0]  sec;
	logic [cal_pkg::CHS_W-1:0]  chs;
	logic [cal_pkg::LBAO_W-1:0] lba;

	assign en       = !valid_q || m_tready;
	assign in_ready = en;

	// Clamp large cylinders, pack the CHS bytes, and zero the field the command does not use
	always_comb begin
		cyl  = in_data.cyl;
		head = in_data.head;
		sec  = in_data.rem[cal_pkg::SPT_W-1:0] + 6'd1;
		if (in_data.clamp) begin
			cyl  = cal_pkg::CYL_SENTINEL;
			head = geom.heads - 8'd1;
			sec  = geom.spt;
		end
		chs = {cyl[7:0], cyl[9:8], sec, head};
		lba = in_data.lba_res;
		if (in_data.cmd == cal_pkg::CMD_CHS_TO_LBA) begin
			chs = '0;
		end else begin
			lba = '0;
			if (in_data.zero) chs = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_q <= {chs, lba};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = tdata_q;

endmodule

>>> hdl/chs_lba_address_converter_top.sv
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// s_*      s_tvalid / s_tready  tdata: chs_in, lba_in; tuser: command
// m_*      m_tvalid / m_tready  tdata: lba_out, chs_out
// cfg_*    cfg_valid/cfg_ready  cfg_index (0 sectors_per_track, 1 head_count), cfg_data
//
// Takes one transfer per cycle unless m_tready stalls; each result passes through:
// three front stages (unpack with first multiply, second multiply, sector add), eighteen
// divider stages with one 24-bit compare and subtract each (ten cylinder bits, eight head
// bits), and the output register. Reset clears all valid bits and loads geometry 63/255.
// A stall holds each full stage until the next one frees; empty stages fill up.

module chs_lba_address_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // chs_in[23:0], lba_in[55:24]
	input  logic [0:0]  s_tuser,   // command[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // lba_out[23:0], chs_out[47:24]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [cal_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cal_pkg::CFG_DAT_W-1:0] cfg_data
);

	localparam int unsigned N_STEP = 18;

	logic [cal_pkg::SPT_W-1:0]   spt_q;
	logic [cal_pkg::HEADS_W-1:0] heads_q;
	logic [cal_pkg::PCYL_W-1:0]  per_cyl_q;
	logic [cal_pkg::SPT_W-1:0]   spt_d;
	logic [cal_pkg::HEADS_W-1:0] heads_d;
	cal_pkg::cal_geom_t          geom;

	cal_pkg::cal_div_t step_data  [0:N_STEP];
	logic              step_valid [0:N_STEP];
	logic              step_ready [0:N_STEP];

	// Geometry registers
	assign cfg_ready = 1'b1;

	always_comb begin
		spt_d   = spt_q;
		heads_d = heads_q;
		if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cal_pkg::CFG_SPT:   spt_d   = cfg_data[cal_pkg::SPT_W-1:0];
				cal_pkg::CFG_HEADS: heads_d = cfg_data;
				default: ;
			endcase
		end
	end

	// Load the geometry and its sectors per cylinder in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q     <= cal_pkg::SPT_RESET;
			heads_q   <= cal_pkg::HEADS_RESET;
			per_cyl_q <= {8'd0, cal_pkg::SPT_RESET} * {6'd0, cal_pkg::HEADS_RESET};
		end else begin
			spt_q     <= spt_d;
			heads_q   <= heads_d;
			per_cyl_q <= {8'd0, spt_d} * {6'd0, heads_d};
		end
	end

	assign geom.spt     = spt_q;
	assign geom.heads   = heads_q;
	assign geom.per_cyl = per_cyl_q;
	assign geom.zero    = (spt_q == '0) || (heads_q == '0);

	cal_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser[0]),
		.in_chs    (s_tdata[23:0]),
		.in_lba    (s_tdata[55:24]),
		.out_valid (step_valid[0]),
		.out_ready (step_ready[0]),
		.out_data  (step_data[0])
	);

	// Divider: cylinder bits high to low, then head bits high to low
	for (genvar k = 0; k < N_STEP; k++) begin : g_step
		localparam bit          HEAD_PH = (k >= cal_pkg::CYL_W);
		localparam int unsigned SH      = HEAD_PH ? (N_STEP - 1 - k)
			: (cal_pkg::CYL_W - 1 - k);

		cal_div_step #(
			.SHIFT      (SH),
			.HEAD_PHASE (HEAD_PH)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.geom      (geom),
			.in_valid  (step_valid[k]),
			.in_ready  (step_ready[k]),
			.in_data   (step_data[k]),
			.out_valid (step_valid[k+1]),
			.out_ready (step_ready[k+1]),
			.out_data  (step_data[k+1])
		);
	end

	cal_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.in_valid (step_valid[N_STEP]),
		.in_ready (step_ready[N_STEP]),
		.in_data  (step_data[N_STEP]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
